// File: sv/clns_pkg.sv
package clns_pkg;

    localparam int STEP_IDX_W = 4;
    localparam int WAIT_W     = 16;

    // request modes
    localparam logic [2:0] MODE_CMD    = 3'd0;
    localparam logic [2:0] MODE_DATA   = 3'd1;
    localparam logic [2:0] MODE_CURSOR = 3'd2;
    localparam logic [2:0] MODE_INIT   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    localparam logic [7:0] DDRAM_ROW1_BASE = 8'h80;
    localparam logic [7:0] DDRAM_ROW2_BASE = 8'hC0;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    localparam logic [WAIT_W-1:0] WAIT_NONE     = 16'd0;
    localparam logic [WAIT_W-1:0] WAIT_CLEAR_US = 16'd2000;
    localparam logic [WAIT_W-1:0] WAIT_PWRUP_US = 16'd40000;
    localparam logic [WAIT_W-1:0] WAIT_INIT1_US = 16'd5000;
    localparam logic [WAIT_W-1:0] WAIT_INIT2_US = 16'd150;

    localparam logic [STEP_IDX_W-1:0] CNT_NONE = 4'd0;
    localparam logic [STEP_IDX_W-1:0] CNT_BYTE = 4'd2;
    localparam logic [STEP_IDX_W-1:0] CNT_INIT = 4'd13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHOW
    } ctrl_state_t;

    typedef struct packed {
        logic strobe;
        logic rs;
        logic [3:0] nib;
        logic [WAIT_W-1:0] wait_us;
    } step_t;

    typedef struct packed {
        logic capture;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic out_last;
    } dp_status_t;

    function automatic step_t mk_step(input logic strobe, input logic [3:0] nib,
                                      input logic [WAIT_W-1:0] wait_us);
        step_t s;
        s.strobe  = strobe;
        s.rs      = RS_INSTR;
        s.nib     = nib;
        s.wait_us = wait_us;
        return s;
    endfunction

    // power-on run, one entry per bus step
    function automatic step_t init_step(input logic [STEP_IDX_W-1:0] idx);
        step_t s;
        case (idx)
            4'd0:    s = mk_step(1'b0, 4'h0, WAIT_PWRUP_US);
            4'd1:    s = mk_step(1'b1, 4'h3, WAIT_INIT1_US);
            4'd2:    s = mk_step(1'b1, 4'h3, WAIT_INIT2_US);
            4'd3:    s = mk_step(1'b1, 4'h3, WAIT_NONE);
            4'd4:    s = mk_step(1'b1, 4'h2, WAIT_NONE);
            4'd5:    s = mk_step(1'b1, 4'h2, WAIT_NONE);
            4'd6:    s = mk_step(1'b1, 4'h8, WAIT_NONE);
            4'd7:    s = mk_step(1'b1, 4'h0, WAIT_NONE);
            4'd8:    s = mk_step(1'b1, 4'hE, WAIT_NONE);
            4'd9:    s = mk_step(1'b1, 4'h0, WAIT_NONE);
            4'd10:   s = mk_step(1'b1, 4'h1, WAIT_CLEAR_US);
            4'd11:   s = mk_step(1'b1, 4'h0, WAIT_NONE);
            4'd12:   s = mk_step(1'b1, 4'h6, WAIT_NONE);
            default: s = mk_step(1'b0, 4'h0, WAIT_NONE);
        endcase
        return s;
    endfunction

endpackage

// File: sv/char_lcd_nibble_sequencer_core.sv
// Channel   Handshake             Payload
// request   in_valid / in_ready   mode, byte_value, row, column
// step      out_valid / out_ready is_strobe, reg_select, nibble, wait_after_us, last
//
// One request at a time: captured in idle, first step loaded into the output
// register in the load state, then one step beat per cycle while out_ready is
// high. A request that yields no steps returns to idle from the load state.
// Step count comes from the count and step index registers in the datapath.
// Reset (rst_n low) returns the controller to idle; a stalled beat holds.
module char_lcd_nibble_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [1:0]  row,
    input  logic [4:0]  column,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_strobe,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [15:0] wait_after_us,
    output logic        last
);
    import clns_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    clns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    clns_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .byte_value    (byte_value),
        .row           (row),
        .column        (column),
        .cmd           (cmd),
        .status        (status),
        .is_strobe     (is_strobe),
        .reg_select    (reg_select),
        .nibble        (nibble),
        .wait_after_us (wait_after_us),
        .last          (last)
    );

endmodule

// File: sv/clns_ctrl.sv
module clns_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  clns_pkg::dp_status_t status,
    output clns_pkg::dp_cmd_t    cmd
);
    import clns_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = status.empty ? ST_IDLE : ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready && status.out_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOAD:
            begin
                cmd.emit = !status.empty;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                // next step loads straight into the output register as this beat leaves
                cmd.emit  = out_ready && !status.out_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/clns_datapath.sv
module clns_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           mode,
    input  logic [7:0]           byte_value,
    input  logic [1:0]           row,
    input  logic [4:0]           column,
    input  clns_pkg::dp_cmd_t    cmd,
    output clns_pkg::dp_status_t status,
    output logic                 is_strobe,
    output logic                 reg_select,
    output logic [3:0]           nibble,
    output logic [15:0]          wait_after_us,
    output logic                 last
);
    import clns_pkg::*;

    // captured request
    logic                  init_reg;
    logic [7:0]            byte_reg;
    logic                  rs_reg;
    logic                  clr_wait_reg;
    logic [STEP_IDX_W-1:0] count_reg;
    logic [STEP_IDX_W-1:0] idx_reg;

    logic                  init_next;
    logic [7:0]            byte_next;
    logic                  rs_next;
    logic                  clr_wait_next;
    logic [STEP_IDX_W-1:0] count_next;

    logic [7:0] addr;
    step_t      cur_step;
    logic       cur_last;

    step_t out_reg;
    logic  out_last_reg;

    // request decode
    always_comb
    begin
        addr          = {3'b000, column} - 8'd1;
        init_next     = 1'b0;
        byte_next     = byte_value;
        rs_next       = RS_INSTR;
        clr_wait_next = 1'b0;
        count_next    = CNT_NONE;
        case (mode)
            MODE_CMD:
            begin
                count_next = CNT_BYTE;
            end
            MODE_DATA:
            begin
                rs_next    = RS_DATA;
                count_next = CNT_BYTE;
            end
            MODE_CURSOR:
            begin
                if (row == ROW_FIRST)
                begin
                    byte_next  = addr | DDRAM_ROW1_BASE;
                    count_next = CNT_BYTE;
                end
                else if (row == ROW_SECOND)
                begin
                    byte_next  = addr | DDRAM_ROW2_BASE;
                    count_next = CNT_BYTE;
                end
            end
            MODE_INIT:
            begin
                init_next  = 1'b1;
                count_next = CNT_INIT;
            end
            MODE_CLEAR:
            begin
                byte_next     = CMD_CLEAR;
                clr_wait_next = 1'b1;
                count_next    = CNT_BYTE;
            end
            default:
            begin
                count_next = CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            init_reg     <= init_next;
            byte_reg     <= byte_next;
            rs_reg       <= rs_next;
            clr_wait_reg <= clr_wait_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_NONE;
            idx_reg   <= '0;
        end
        else if (cmd.capture)
        begin
            count_reg <= count_next;
            idx_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    // step generation from the current index
    always_comb
    begin
        if (init_reg)
        begin
            cur_step = init_step(idx_reg);
        end
        else
        begin
            cur_step.strobe = 1'b1;
            cur_step.rs     = rs_reg;
            if (idx_reg == '0)
            begin
                cur_step.nib     = byte_reg[7:4];
                cur_step.wait_us = WAIT_NONE;
            end
            else
            begin
                cur_step.nib     = byte_reg[3:0];
                cur_step.wait_us = clr_wait_reg ? WAIT_CLEAR_US : WAIT_NONE;
            end
        end
        cur_last = (idx_reg == count_reg - 4'd1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg      <= cur_step;
            out_last_reg <= cur_last;
        end
    end

    assign status.empty    = (count_reg == CNT_NONE);
    assign status.out_last = out_last_reg;

    assign is_strobe     = out_reg.strobe;
    assign reg_select    = out_reg.rs;
    assign nibble        = out_reg.nib;
    assign wait_after_us = out_reg.wait_us;
    assign last          = out_last_reg;

endmodule
